[rtl/gs_pkg.sv]
// ----------------------------------------------------------------------------
// gs_pkg
// Shared widths, codes, types and helpers of the fixed-point Gauss-Seidel
// solver.
// ----------------------------------------------------------------------------
package gs_pkg;

  localparam int MAX_ORDER  = 16;
  localparam int IDX_W      = $clog2(MAX_ORDER);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIM_W      = 5;
  localparam int SWEEP_W    = 16;
  localparam int NORM_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  // exact sum of b and MAX_ORDER saturated products
  localparam int ACC_W      = VALUE_BITS + IDX_W + 1;
  // (|s| << FRAC) + |d|/2 needs one bit more than the shifted magnitude
  localparam int DIV_BITS   = VALUE_BITS + FRAC_BITS + 1;

  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SWEEPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd2;

  typedef enum logic [1:0] {
    CMD_MATRIX = 2'd0,
    CMD_VECTOR = 2'd1,
    CMD_START  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_CONVERGED = 2'd0,
    STAT_LIMIT     = 2'd1,
    STAT_ZERO_DIAG = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RES_ROW,
    S_RES_DRAIN,
    S_RES_SQ,
    S_RES_WAIT,
    S_DECIDE,
    S_SWP_ROW,
    S_SWP_DRAIN,
    S_DIV,
    S_OUT,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic init;       // load accumulator with b
    logic mul;        // multiply-subtract one element
    logic square;     // square the saturated accumulator into the norm
    logic clr_total;  // clear the norm
  } mac_ctl_t;

  function automatic logic [VALUE_BITS-1:0] mag(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] u;
    u = v;
    return u[VALUE_BITS-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

[rtl/gauss_seidel_solver.sv]
// ----------------------------------------------------------------------------
// gauss_seidel_solver
// Fixed-point Q16.16 Gauss-Seidel solver over memory-held A, b and x.
// ----------------------------------------------------------------------------
// Load beats are taken one per cycle while busy is low and written to memory in
// that cycle. A start beat holds busy high: one residual pass, then per sweep a
// row-by-row update through the bit-serial divider plus a residual pass; n
// results then follow one per cycle, busy dropping right after the last.
// rst (synchronous) returns the registers to 16/100/1 and clears estimates.
module gauss_seidel_solver (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             command,
  input  logic [gs_pkg::IDX_W-1:0]               row,
  input  logic [gs_pkg::IDX_W-1:0]               column,
  input  logic signed [gs_pkg::VALUE_BITS-1:0]   value,
  input  logic                                   wr_en,
  input  logic [gs_pkg::CFG_IDX_W-1:0]           wr_index,
  input  logic [gs_pkg::CFG_DATA_W-1:0]          wr_data,
  output logic                                   result_strobe,
  output logic [gs_pkg::IDX_W-1:0]               index,
  output logic signed [gs_pkg::VALUE_BITS-1:0]   solution,
  output logic                                   last,
  output logic [gs_pkg::SWEEP_W-1:0]             sweeps_done,
  output logic [1:0]                             status,
  output logic [gs_pkg::NORM_W-1:0]              residual_squared
);

  localparam int IW = gs_pkg::IDX_W;
  localparam int VB = gs_pkg::VALUE_BITS;
  localparam logic [gs_pkg::DIM_W-1:0] ORDER_MAX = gs_pkg::DIM_W'(gs_pkg::MAX_ORDER);

  gs_pkg::state_t   state;
  gs_pkg::state_t   state_next;
  gs_pkg::mac_ctl_t mac_ctl;
  gs_pkg::status_t  stat;

  logic [gs_pkg::DIM_W-1:0]  dimension;
  logic [gs_pkg::SWEEP_W-1:0] max_sweeps;
  logic [gs_pkg::NORM_W-1:0] tolerance_squared;
  logic [gs_pkg::DIM_W-1:0]  order_n;
  logic [gs_pkg::DIM_W-1:0]  order_m1;
  logic [IW-1:0]             nm1;

  logic [IW-1:0]             i;
  logic [IW-1:0]             j;
  logic [1:0]                cnt;
  logic [gs_pkg::SWEEP_W-1:0] sweep_count;
  logic                      zero_diag;
  logic signed [VB-1:0]      diag;
  logic                      d1_valid;
  logic                      d1_first;
  logic                      d1_use;
  logic                      d1_diag;
  logic                      od_valid;
  logic                      od_last;
  logic [IW-1:0]             od_index;

  logic                      accept;
  logic                      go_sweep;
  logic                      mat_we;
  logic                      vec_we;
  logic                      est_clear;
  logic                      est_we;
  logic                      div_start;
  logic                      div_done;
  logic [gs_pkg::ADDR_W-1:0] mat_waddr;
  logic [gs_pkg::ADDR_W-1:0] mat_raddr;
  logic [IW-1:0]             est_raddr;
  logic signed [VB-1:0]      mat_rdata;
  logic signed [VB-1:0]      vec_rdata;
  logic signed [VB-1:0]      est_rdata;
  logic signed [VB-1:0]      acc_sat;
  logic signed [VB-1:0]      quot;
  logic [gs_pkg::NORM_W-1:0] total;

  assign accept = start && !busy;

  // order in use: zero taken as one, capped at the built size
  always_comb begin
    if (dimension == '0) begin
      order_n = gs_pkg::DIM_W'(1);
    end else if (dimension > ORDER_MAX) begin
      order_n = ORDER_MAX;
    end else begin
      order_n = dimension;
    end
    order_m1 = order_n - 1'b1;
    nm1      = order_m1[IW-1:0];
  end

  assign go_sweep = !zero_diag && (sweep_count < max_sweeps)
                    && (total > tolerance_squared);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension         <= gs_pkg::DIM_W'(16);
      max_sweeps        <= gs_pkg::SWEEP_W'(100);
      tolerance_squared <= gs_pkg::NORM_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        gs_pkg::REG_DIMENSION:  dimension         <= wr_data[gs_pkg::DIM_W-1:0];
        gs_pkg::REG_MAX_SWEEPS: max_sweeps        <= wr_data[gs_pkg::SWEEP_W-1:0];
        gs_pkg::REG_TOLERANCE:  tolerance_squared <= wr_data[gs_pkg::NORM_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gs_pkg::S_IDLE: begin
        if (accept && command == gs_pkg::CMD_START) begin
          state_next = gs_pkg::S_RES_ROW;
        end
      end
      gs_pkg::S_RES_ROW: begin
        if (j == nm1) state_next = gs_pkg::S_RES_DRAIN;
      end
      gs_pkg::S_RES_DRAIN: begin
        if (cnt == 2'd1) state_next = gs_pkg::S_RES_SQ;
      end
      gs_pkg::S_RES_SQ: begin
        state_next = (i == nm1) ? gs_pkg::S_RES_WAIT : gs_pkg::S_RES_ROW;
      end
      gs_pkg::S_RES_WAIT: state_next = gs_pkg::S_DECIDE;
      gs_pkg::S_DECIDE: begin
        state_next = go_sweep ? gs_pkg::S_SWP_ROW : gs_pkg::S_OUT;
      end
      gs_pkg::S_SWP_ROW: begin
        if (j == nm1) state_next = gs_pkg::S_SWP_DRAIN;
      end
      gs_pkg::S_SWP_DRAIN: begin
        if (cnt == 2'd2) state_next = gs_pkg::S_DIV;
      end
      gs_pkg::S_DIV: begin
        if (div_done) begin
          state_next = (i == nm1) ? gs_pkg::S_RES_ROW : gs_pkg::S_SWP_ROW;
        end
      end
      gs_pkg::S_OUT: begin
        if (i == nm1) state_next = gs_pkg::S_FLUSH;
      end
      gs_pkg::S_FLUSH: begin
        if (cnt == 2'd1) state_next = gs_pkg::S_IDLE;
      end
      default: state_next = gs_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy              = (state != gs_pkg::S_IDLE);
    mat_we            = 1'b0;
    vec_we            = 1'b0;
    est_clear         = 1'b0;
    est_we            = 1'b0;
    div_start         = 1'b0;
    mac_ctl.init      = d1_valid && d1_first;
    mac_ctl.mul       = d1_valid && d1_use;
    mac_ctl.square    = 1'b0;
    mac_ctl.clr_total = 1'b0;
    unique case (state)
      gs_pkg::S_IDLE: begin
        if (accept) begin
          unique case (command)
            gs_pkg::CMD_MATRIX: mat_we    = 1'b1;
            gs_pkg::CMD_VECTOR: vec_we    = 1'b1;
            gs_pkg::CMD_START:  est_clear = 1'b1;
            default: ;
          endcase
        end
      end
      gs_pkg::S_RES_ROW: mac_ctl.clr_total = (i == '0) && (j == '0);
      gs_pkg::S_RES_SQ:  mac_ctl.square    = 1'b1;
      gs_pkg::S_SWP_DRAIN: div_start = (cnt == 2'd2);
      gs_pkg::S_DIV:     est_we = div_done;
      default: ;
    endcase
  end

  assign mat_waddr = {row, column};
  assign mat_raddr = {i, j};
  assign est_raddr = (state == gs_pkg::S_OUT) ? i : j;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // row, column, sweep and drain counters
  always_ff @(posedge clk) begin
    if (rst) begin
      i           <= '0;
      j           <= '0;
      cnt         <= '0;
      sweep_count <= '0;
      stat        <= gs_pkg::STAT_CONVERGED;
    end else begin
      if (state == gs_pkg::S_RES_DRAIN || state == gs_pkg::S_SWP_DRAIN ||
          state == gs_pkg::S_FLUSH) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      case (state)
        gs_pkg::S_IDLE: begin
          if (accept && command == gs_pkg::CMD_START) begin
            i           <= '0;
            j           <= '0;
            sweep_count <= '0;
          end
        end
        gs_pkg::S_RES_ROW, gs_pkg::S_SWP_ROW: begin
          j <= (j == nm1) ? '0 : j + 1'b1;
        end
        gs_pkg::S_RES_SQ: begin
          if (i != nm1) i <= i + 1'b1;
        end
        gs_pkg::S_DECIDE: begin
          i <= '0;
          j <= '0;
          if (zero_diag) begin
            stat <= gs_pkg::STAT_ZERO_DIAG;
          end else if (total <= tolerance_squared) begin
            stat <= gs_pkg::STAT_CONVERGED;
          end else begin
            stat <= gs_pkg::STAT_LIMIT;
          end
        end
        gs_pkg::S_DIV: begin
          if (div_done) begin
            if (i == nm1) begin
              i           <= '0;
              sweep_count <= sweep_count + 1'b1;
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        gs_pkg::S_OUT: i <= i + 1'b1;
        default: ;
      endcase
    end
  end

  // read-data alignment and diagonal capture
  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid  <= 1'b0;
      zero_diag <= 1'b0;
    end else begin
      d1_valid <= (state == gs_pkg::S_RES_ROW) || (state == gs_pkg::S_SWP_ROW);
      if (est_clear) begin
        zero_diag <= 1'b0;
      end else if (d1_valid && d1_diag && mat_rdata == '0) begin
        zero_diag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    d1_first <= (j == '0);
    d1_diag  <= (j == i);
    d1_use   <= !((state == gs_pkg::S_SWP_ROW) && (j == i));
    if (d1_valid && d1_diag) begin
      diag <= mat_rdata;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      od_valid      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      od_valid      <= (state == gs_pkg::S_OUT);
      result_strobe <= od_valid;
    end
  end

  always_ff @(posedge clk) begin
    od_index         <= i;
    od_last          <= (i == nm1);
    index            <= od_index;
    solution         <= est_rdata;
    last             <= od_valid && od_last;
    sweeps_done      <= sweep_count;
    status           <= stat;
    residual_squared <= total;
  end

  gs_store u_store (
    .clk       (clk),
    .rst       (rst),
    .mat_we    (mat_we),
    .mat_waddr (mat_waddr),
    .mat_wdata (value),
    .mat_raddr (mat_raddr),
    .mat_rdata (mat_rdata),
    .vec_we    (vec_we),
    .vec_waddr (row),
    .vec_wdata (value),
    .vec_raddr (i),
    .vec_rdata (vec_rdata),
    .est_clear (est_clear),
    .est_we    (est_we),
    .est_waddr (i),
    .est_wdata (quot),
    .est_raddr (est_raddr),
    .est_rdata (est_rdata)
  );

  gs_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mac_ctl),
    .a        (mat_rdata),
    .x        (est_rdata),
    .init_val (vec_rdata),
    .acc_sat  (acc_sat),
    .total    (total)
  );

  gs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc_sat),
    .den   (diag),
    .done  (div_done),
    .quot  (quot)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result beat outside a solve");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == gs_pkg::CMD_START) |=> busy)
    else $error("start beat did not launch a solve");

  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last |-> result_strobe)
    else $error("last flag without a result beat");

  a_zero_diag_sweeps: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && status == gs_pkg::STAT_ZERO_DIAG) |-> (sweeps_done == '0))
    else $error("sweeps reported despite a zero diagonal");

endmodule

[rtl/gs_store.sv]
// ----------------------------------------------------------------------------
// gs_store
// Matrix, vector and estimate memories with registered reads. The
// estimate entries carry valid bits so that a cleared entry reads as zero.
// ----------------------------------------------------------------------------
module gs_store (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   mat_we,
  input  logic [gs_pkg::ADDR_W-1:0]              mat_waddr,
  input  logic signed [gs_pkg::VALUE_BITS-1:0]   mat_wdata,
  input  logic [gs_pkg::ADDR_W-1:0]              mat_raddr,
  output logic signed [gs_pkg::VALUE_BITS-1:0]   mat_rdata,
  input  logic                                   vec_we,
  input  logic [gs_pkg::IDX_W-1:0]               vec_waddr,
  input  logic signed [gs_pkg::VALUE_BITS-1:0]   vec_wdata,
  input  logic [gs_pkg::IDX_W-1:0]               vec_raddr,
  output logic signed [gs_pkg::VALUE_BITS-1:0]   vec_rdata,
  input  logic                                   est_clear,
  input  logic                                   est_we,
  input  logic [gs_pkg::IDX_W-1:0]               est_waddr,
  input  logic signed [gs_pkg::VALUE_BITS-1:0]   est_wdata,
  input  logic [gs_pkg::IDX_W-1:0]               est_raddr,
  output logic signed [gs_pkg::VALUE_BITS-1:0]   est_rdata
);

  logic signed [gs_pkg::VALUE_BITS-1:0] mat_mem [gs_pkg::MAX_ORDER*gs_pkg::MAX_ORDER];
  logic signed [gs_pkg::VALUE_BITS-1:0] vec_mem [gs_pkg::MAX_ORDER];
  logic signed [gs_pkg::VALUE_BITS-1:0] est_mem [gs_pkg::MAX_ORDER];
  logic [gs_pkg::MAX_ORDER-1:0]         est_valid;
  logic signed [gs_pkg::VALUE_BITS-1:0] est_q;
  logic                                 est_q_valid;

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
    mat_rdata <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= vec_wdata;
    end
    vec_rdata <= vec_mem[vec_raddr];
  end

  always_ff @(posedge clk) begin
    if (est_we) begin
      est_mem[est_waddr] <= est_wdata;
    end
    est_q <= est_mem[est_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || est_clear) begin
      est_valid   <= '0;
      est_q_valid <= 1'b0;
    end else begin
      if (est_we) begin
        est_valid[est_waddr] <= 1'b1;
      end
      est_q_valid <= est_valid[est_raddr];
    end
  end

  assign est_rdata = est_q_valid ? est_q : '0;

endmodule

[rtl/gs_mac.sv]
// ----------------------------------------------------------------------------
// gs_mac
// Two-stage multiply, round and accumulate unit: b minus the sum of rounded
// products, and the squared residual norm of the saturated row sums.
// ----------------------------------------------------------------------------
module gs_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  gs_pkg::mac_ctl_t                     ctl,
  input  logic signed [gs_pkg::VALUE_BITS-1:0] a,
  input  logic signed [gs_pkg::VALUE_BITS-1:0] x,
  input  logic signed [gs_pkg::VALUE_BITS-1:0] init_val,
  output logic signed [gs_pkg::VALUE_BITS-1:0] acc_sat,
  output logic [gs_pkg::NORM_W-1:0]            total
);

  localparam int VB = gs_pkg::VALUE_BITS;
  localparam int AW = gs_pkg::ACC_W;
  localparam int PW = 2 * VB;
  localparam logic signed [AW-1:0] ACC_HI = {{(AW-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_LO = {{(AW-VB+1){1'b1}}, {(VB-1){1'b0}}};
  localparam logic [PW-1:0] HALF    = {{(PW-gs_pkg::FRAC_BITS){1'b0}}, 1'b1,
                                       {(gs_pkg::FRAC_BITS-1){1'b0}}};
  localparam logic [PW-1:0] NEG_MAG = {{(PW-VB){1'b0}}, 1'b1, {(VB-1){1'b0}}};
  localparam logic [PW-1:0] POS_MAX = NEG_MAG - 1'b1;
  localparam logic [PW-1:0] NORM_MAX = {{(PW-gs_pkg::NORM_W){1'b0}},
                                        {gs_pkg::NORM_W{1'b1}}};

  logic signed [AW-1:0] acc;
  logic [PW-1:0]        prod;
  logic                 p_valid;
  logic                 p_square;
  logic                 p_neg;
  logic [VB-1:0]        sa;
  logic [VB-1:0]        sb;
  logic [PW-1:0]        rnd;
  logic signed [VB-1:0] val;
  logic [PW-1:0]        tsum;

  always_comb begin
    if (acc > ACC_HI) begin
      acc_sat = ACC_HI[VB-1:0];
    end else if (acc < ACC_LO) begin
      acc_sat = ACC_LO[VB-1:0];
    end else begin
      acc_sat = acc[VB-1:0];
    end
  end

  // square mode feeds the saturated row sum to both sides
  assign sa = ctl.square ? acc_sat : a;
  assign sb = ctl.square ? acc_sat : x;

  always_ff @(posedge clk) begin
    prod     <= PW'(gs_pkg::mag(sa)) * PW'(gs_pkg::mag(sb));
    p_neg    <= sa[VB-1] ^ sb[VB-1];
    p_square <= ctl.square;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= ctl.mul | ctl.square;
    end
  end

  // round half away from zero on the magnitude, then saturate
  assign rnd = (prod + HALF) >> gs_pkg::FRAC_BITS;

  always_comb begin
    if (p_neg) begin
      val = (rnd >= NEG_MAG) ? ACC_LO[VB-1:0] : (~rnd[VB-1:0] + 1'b1);
    end else begin
      val = (rnd > POS_MAX) ? ACC_HI[VB-1:0] : rnd[VB-1:0];
    end
  end

  assign tsum = {{(PW-gs_pkg::NORM_W){1'b0}}, total} + rnd;

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      acc <= AW'(init_val);
    end else if (p_valid && !p_square) begin
      acc <= acc - AW'(val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_total) begin
      total <= '0;
    end else if (p_valid && p_square) begin
      total <= (tsum > NORM_MAX) ? NORM_MAX[gs_pkg::NORM_W-1:0]
                                 : tsum[gs_pkg::NORM_W-1:0];
    end
  end

endmodule

[rtl/gs_div.sv]
// ----------------------------------------------------------------------------
// gs_div
// Restoring divider, one quotient bit per cycle: rounded (s << 16) / d with
// the sign applied and the result saturated.
// ----------------------------------------------------------------------------
module gs_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [gs_pkg::VALUE_BITS-1:0] num,
  input  logic signed [gs_pkg::VALUE_BITS-1:0] den,
  output logic                                 done,
  output logic signed [gs_pkg::VALUE_BITS-1:0] quot
);

  localparam int VB = gs_pkg::VALUE_BITS;
  localparam int DB = gs_pkg::DIV_BITS;
  localparam int CW = $clog2(DB);
  localparam logic [DB-1:0] NEG_MAG = {{(DB-VB){1'b0}}, 1'b1, {(VB-1){1'b0}}};
  localparam logic [DB-1:0] POS_MAX = NEG_MAG - 1'b1;

  logic [DB-1:0] dvd;
  logic [VB-1:0] rem;
  logic [VB-1:0] dmag;
  logic          neg;
  logic          run;
  logic [CW-1:0] cnt;
  logic [VB:0]   trial;
  logic [VB:0]   diff;
  logic          ge;

  assign trial = {rem, dvd[DB-1]};
  assign diff  = trial - {1'b0, dmag};
  assign ge    = trial >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= DB'({gs_pkg::mag(num), {gs_pkg::FRAC_BITS{1'b0}}})
            + DB'(gs_pkg::mag(den) >> 1);
      dmag <= gs_pkg::mag(den);
      neg  <= num[VB-1] ^ den[VB-1];
      rem  <= '0;
      cnt  <= '0;
    end else if (run) begin
      rem <= ge ? diff[VB-1:0] : trial[VB-1:0];
      dvd <= {dvd[DB-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CW'(DB - 1));
      if (start) begin
        run <= 1'b1;
      end else if (cnt == CW'(DB - 1)) begin
        run <= 1'b0;
      end
    end
  end

  always_comb begin
    if (neg) begin
      quot = (dvd >= NEG_MAG) ? {1'b1, {(VB-1){1'b0}}} : (~dvd[VB-1:0] + 1'b1);
    end else begin
      quot = (dvd > POS_MAX) ? {1'b0, {(VB-1){1'b1}}} : dvd[VB-1:0];
    end
  end

endmodule

[verif/gauss_seidel_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_seidel_checker
// Watches the load, start, register and result ports of the solver. On each
// accepted start beat it predicts the solution run, then compares every result
// beat field by field against the oldest predicted beat.
// ----------------------------------------------------------------------------
module gauss_seidel_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [1:0]                           command,
  input  logic [gs_pkg::IDX_W-1:0]             row,
  input  logic [gs_pkg::IDX_W-1:0]             column,
  input  logic signed [gs_pkg::VALUE_BITS-1:0] value,
  input  logic                                 wr_en,
  input  logic [gs_pkg::CFG_IDX_W-1:0]         wr_index,
  input  logic [gs_pkg::CFG_DATA_W-1:0]        wr_data,
  input  logic                                 result_strobe,
  input  logic [gs_pkg::IDX_W-1:0]             index,
  input  logic signed [gs_pkg::VALUE_BITS-1:0] solution,
  input  logic                                 last,
  input  logic [gs_pkg::SWEEP_W-1:0]           sweeps_done,
  input  logic [1:0]                           status,
  input  logic [gs_pkg::NORM_W-1:0]            residual_squared,
  output int                                   fail_count,
  output int                                   pending_count,
  output int                                   solve_count
);
  import gs_pkg::*;

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint NEG_MIN = -64'sd2147483648;

  typedef struct {
    logic [IDX_W-1:0]      idx;
    logic [31:0]           x;
    logic                  is_last;
    logic [SWEEP_W-1:0]    sweeps;
    logic [1:0]            stat;
    logic [NORM_W-1:0]     norm;
  } solution_beat_t;

  solution_beat_t solution_q[$];

  longint a_mat[MAX_ORDER][MAX_ORDER];
  longint b_vec[MAX_ORDER];
  longint x_est[MAX_ORDER];
  logic [DIM_W-1:0]   dim_reg;
  logic [SWEEP_W-1:0] sweep_limit;
  longint unsigned    tol_sq;

  function automatic longint clamp_val(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < NEG_MIN) return NEG_MIN;
    return v;
  endfunction

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // magnitudes stay below 2^32, so the product fits 64 bits unsigned
  function automatic longint unsigned round_prod(longint unsigned a, longint unsigned b);
    return (a * b + 64'd32768) >> FRAC_BITS;
  endfunction

  function automatic longint signed_of(longint unsigned m, bit neg);
    if (neg) return (m >= 64'd2147483648) ? NEG_MIN : -longint'(m);
    return (m > 64'd2147483647) ? POS_MAX : longint'(m);
  endfunction

  function automatic longint fix_mul(longint a, longint b);
    return signed_of(round_prod(mag64(a), mag64(b)), (a < 0) != (b < 0));
  endfunction

  function automatic longint fix_div(longint s, longint d);
    longint unsigned ud, num;
    ud = mag64(d);
    num = mag64(s) << FRAC_BITS;
    return signed_of((num + ud / 2) / ud, (s < 0) != (d < 0));
  endfunction

  function automatic longint unsigned norm_of(int n);
    longint unsigned total, m;
    longint acc;
    total = 0;
    for (int i = 0; i < n; i++) begin
      acc = b_vec[i];
      for (int j = 0; j < n; j++) acc -= fix_mul(a_mat[i][j], x_est[j]);
      m = mag64(clamp_val(acc));
      total += round_prod(m, m);
      if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
    end
    return total;
  endfunction

  task automatic solve_and_queue();
    int n;
    int unsigned cnt;
    bit zero_diag;
    longint unsigned rsq;
    longint acc;
    logic [1:0] stat;
    solution_beat_t beat;
    n = (dim_reg == 0) ? 1 : (dim_reg > MAX_ORDER) ? MAX_ORDER : int'(dim_reg);
    for (int i = 0; i < MAX_ORDER; i++) x_est[i] = 0;
    cnt = 0;
    zero_diag = 0;
    for (int i = 0; i < n; i++) if (a_mat[i][i] == 0) zero_diag = 1;
    rsq = norm_of(n);
    if (zero_diag) begin
      stat = STAT_ZERO_DIAG;
    end else begin
      while (cnt < sweep_limit && rsq > tol_sq) begin
        // in-place update: later rows see the new estimates
        for (int i = 0; i < n; i++) begin
          acc = b_vec[i];
          for (int j = 0; j < n; j++)
            if (j != i) acc -= fix_mul(a_mat[i][j], x_est[j]);
          x_est[i] = fix_div(clamp_val(acc), a_mat[i][i]);
        end
        cnt++;
        rsq = norm_of(n);
      end
      stat = (rsq <= tol_sq) ? STAT_CONVERGED : STAT_LIMIT;
    end
    for (int i = 0; i < n; i++) begin
      beat.idx = i[IDX_W-1:0];
      beat.x = 32'(clamp_val(x_est[i]));
      beat.is_last = (i == n - 1);
      beat.sweeps = cnt[SWEEP_W-1:0];
      beat.stat = stat;
      beat.norm = rsq[NORM_W-1:0];
      solution_q.push_back(beat);
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    solve_count = 0;
  end

  assign pending_count = solution_q.size();

  always @(posedge clk) begin
    solution_beat_t want;
    if (rst) begin
      dim_reg = DIM_W'(16);
      sweep_limit = SWEEP_W'(100);
      tol_sq = 1;
      for (int i = 0; i < MAX_ORDER; i++) x_est[i] = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_DIMENSION:  dim_reg = wr_data[DIM_W-1:0];
          REG_MAX_SWEEPS: sweep_limit = wr_data[SWEEP_W-1:0];
          REG_TOLERANCE:  tol_sq = wr_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (command == CMD_MATRIX) a_mat[row][column] = longint'(value);
        else if (command == CMD_VECTOR) b_vec[row] = longint'(value);
        else if (command == CMD_START) begin
          solve_and_queue();
          solve_count++;
        end
      end
      if (result_strobe) begin
        if (solution_q.size() == 0) begin
          report("unexpected result beat", index, 0);
        end else begin
          want = solution_q.pop_front();
          if (index !== want.idx) report("index", index, want.idx);
          if (solution !== want.x) report("solution", solution, want.x);
          if (last !== want.is_last) report("last", last, want.is_last);
          if (sweeps_done !== want.sweeps) report("sweeps_done", sweeps_done, want.sweeps);
          if (status !== want.stat) report("status", status, want.stat);
          if (residual_squared !== want.norm)
            report("residual_squared", residual_squared, want.norm);
        end
      end
    end
  end

endmodule

[verif/gauss_seidel_solver_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_seidel_solver_tb
// Loads small systems into the solver, starts solves under changing register
// settings and sender gaps, and lets the checker predict and compare results.
// ----------------------------------------------------------------------------
module gauss_seidel_solver_tb;
  import gs_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int KIND_DOMINANT  = 0;
  localparam int KIND_WILD      = 1;
  localparam int KIND_ZERO_DIAG = 2;
  // command code the block has no use for
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  logic clk = 0;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] command;
  logic [IDX_W-1:0] row, column;
  logic signed [VALUE_BITS-1:0] value;
  logic wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0] wr_data;
  logic result_strobe;
  logic [IDX_W-1:0] index;
  logic signed [VALUE_BITS-1:0] solution;
  logic last;
  logic [SWEEP_W-1:0] sweeps_done;
  logic [1:0] status;
  logic [NORM_W-1:0] residual_squared;
  int fail_count, pending_count, solve_count;
  int items_sent = 0;
  int idle_pct = 11;
  int cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  gauss_seidel_solver dut (.*);

  gauss_seidel_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("gauss_seidel_solver_tb: errors");
      $finish;
    end
  end

  task automatic send(logic [1:0] cmd, int r, int c, logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    row <= r[IDX_W-1:0];
    column <= c[IDX_W-1:0];
    value <= v;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // idle once every predicted beat is back and the block is not busy
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] dim, logic [31:0] sweeps, logic [31:0] tol);
    wr_en <= 1'b1;
    wr_index <= REG_DIMENSION;
    wr_data <= dim;
    @(posedge clk);
    wr_index <= REG_MAX_SWEEPS;
    wr_data <= sweeps;
    @(posedge clk);
    wr_index <= REG_TOLERANCE;
    wr_data <= tol;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] signed_rand(int unsigned lim);
    logic [31:0] m;
    m = $urandom_range(lim);
    return $urandom_range(1) ? -m : m;
  endfunction

  task automatic load_and_solve(int n, int kind);
    logic [31:0] v;
    int zr;
    zr = $urandom_range(n - 1);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (kind == KIND_WILD) v = $urandom;
        else if (i == j) v = signed_rand(32'h80000) | 32'h40000;
        else v = signed_rand(32'h8000);
        if (kind == KIND_ZERO_DIAG && i == j && i == zr) v = 0;
        send(CMD_MATRIX, i, j, v);
        // noise: ignored command or an entry outside the order in use
        if ($urandom_range(99) < 8)
          send(CMD_IGNORED, $urandom_range(15), $urandom_range(15), $urandom);
        if (n < MAX_ORDER && $urandom_range(99) < 5)
          send(CMD_MATRIX, $urandom_range(n, 15), $urandom_range(15), $urandom);
      end
      v = (kind == KIND_WILD) ? $urandom : signed_rand(32'h100000);
      send(CMD_VECTOR, i, 0, v);
    end
    send(CMD_START, $urandom_range(15), $urandom_range(15), $urandom);
    drain();
  endtask

  initial begin
    int n, kind, pick;
    logic [31:0] tol;
    bit big_done;
    rst <= 1'b1;
    start <= 1'b0;
    command <= CMD_MATRIX;
    row <= '0;
    column <= '0;
    value <= '0;
    wr_en <= 1'b0;
    wr_index <= REG_DIMENSION;
    wr_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme values in a 1x1 system, zero diagonal, ignored command
    set_regs(1, 100, 1);
    send(CMD_MATRIX, 0, 0, 32'h7FFF_FFFF);
    send(CMD_VECTOR, 0, 0, 32'h8000_0000);
    send(CMD_START, 0, 0, 0);
    drain();
    send(CMD_MATRIX, 0, 0, 32'h8000_0000);
    send(CMD_VECTOR, 0, 0, 32'h7FFF_FFFF);
    send(CMD_START, 15, 15, 32'hFFFF_FFFF);
    drain();
    send(CMD_MATRIX, 0, 0, 0);
    send(CMD_IGNORED, 0, 0, 32'h1234_5678);
    send(CMD_START, 0, 0, 0);
    drain();
    set_regs(0, 100, 1);
    load_and_solve(1, KIND_DOMINANT);
    set_regs(2, 1, 0);
    load_and_solve(2, KIND_WILD);
    set_regs(3, 16'hFFFF, 32'hFFFF_FFFF);
    load_and_solve(3, KIND_DOMINANT);

    big_done = 0;
    while (items_sent < 340) begin
      idle_pct = (items_sent < 140) ? 11 : (items_sent < 260) ? 67 : 0;
      if (!big_done && items_sent > 60) begin
        // full order, written as an oversized dimension
        big_done = 1;
        set_regs(32'({$urandom, 5'd31}), 2, $urandom_range(32'hFFFF));
        load_and_solve(MAX_ORDER, KIND_DOMINANT);
      end else begin
        n = ($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(5, 8);
        pick = $urandom_range(99);
        kind = (pick < 70) ? KIND_DOMINANT : (pick < 90) ? KIND_WILD : KIND_ZERO_DIAG;
        pick = $urandom_range(2);
        tol = (pick == 0) ? 32'h0 : (pick == 1) ? $urandom_range(32'hFFFF) : $urandom;
        set_regs(32'({$urandom_range(7), n[4:0]}), $urandom_range(1, 12), tol);
        load_and_solve(n, kind);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("sent %0d beats including %0d solves over orders 1 to 16, three gap settings",
             items_sent, solve_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("gauss_seidel_solver_tb: clean");
    end else begin
      $display("gauss_seidel_solver_tb: errors");
    end
    $finish;
  end

endmodule
